### hw/rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// Shared types, widths and codes of the stereo level meter.
// ----------------------------------------------------------------------------
package slm_pkg;

  // Data widths
  localparam int SAMPLE_BITS = 24;
  localparam int THR_BITS    = 24;
  localparam int COUNT_BITS  = 32;
  localparam int ENERGY_BITS = 64;
  localparam int SQ_BITS     = 2 * SAMPLE_BITS;

  // Iteration counts of the divider (one quotient bit a cycle) and the root
  // (one root bit a cycle)
  localparam int DIV_STEPS  = ENERGY_BITS;
  localparam int ROOT_STEPS = ENERGY_BITS / 2;
  localparam int ITER_BITS  = $clog2(DIV_STEPS);

  // Configuration port
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;
  localparam int REG_IDX_BITS  = APB_ADDR_BITS - 2;

  localparam logic [REG_IDX_BITS-1:0] REG_CLIP_THRESHOLD = REG_IDX_BITS'(0);
  localparam logic [THR_BITS-1:0]     CLIP_THR_RESET     = THR_BITS'(4194304);

  // Request codes
  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_READ   = 1'b1
  } req_type_e;

  // Input request
  typedef struct packed {
    req_type_e                     req_type;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          nonfinite_in;
  } in_req_t;

  // Result
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] out_left;
    logic signed [SAMPLE_BITS-1:0] out_right;
    logic [SAMPLE_BITS-1:0]        rms_level;
    logic [SAMPLE_BITS-1:0]        peak_level;
    logic [COUNT_BITS-1:0]         invalid_count;
    logic [COUNT_BITS-1:0]         clip_count;
  } out_res_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_L,
    ST_SQ_R,
    ST_MIX,
    ST_ACC,
    ST_DIV,
    ST_ROOT,
    ST_EMIT
  } slm_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take the request, init magnitudes and iterators
    logic square_l;
    logic square_r;
    logic mix;        // half energy of the frame, peak and clip update
    logic accumulate; // energy sum and frame count
    logic div_step;
    logic root_step;
    logic emit;       // load the output register, clear on read
  } slm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic in_read;
    logic in_nonfinite;
    logic frames_zero;
    logic div_last;
    logic root_last;
    logic out_free;
  } slm_status_t;

  // Magnitude of a two's complement sample; the most negative value maps to
  // 2^(SAMPLE_BITS-1), which still fits unsigned
  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [SAMPLE_BITS-1:0] x);
    logic [SAMPLE_BITS-1:0] m;
    m = x[SAMPLE_BITS-1] ? (~x + SAMPLE_BITS'(1)) : x;
    return m;
  endfunction

endpackage

### hw/rtl/slm_ctrl.sv
// ----------------------------------------------------------------------------
// slm_ctrl
// Sequencer of the level meter: steps the datapath through one request.
// ----------------------------------------------------------------------------
module slm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  slm_pkg::slm_status_t status_i,
  output slm_pkg::slm_cmd_t    cmd_o
);
  import slm_pkg::*;

  slm_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.in_read) begin
            state_d = status_i.frames_zero ? ST_EMIT : ST_DIV;
          end else if (status_i.in_nonfinite) begin
            state_d = ST_EMIT;
          end else begin
            state_d = ST_SQ_L;
          end
        end
      end
      ST_SQ_L: begin
        cmd_o.square_l = 1'b1;
        state_d        = ST_SQ_R;
      end
      ST_SQ_R: begin
        cmd_o.square_r = 1'b1;
        state_d        = ST_MIX;
      end
      ST_MIX: begin
        cmd_o.mix = 1'b1;
        state_d   = ST_ACC;
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d          = ST_EMIT;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/slm_dp.sv
// ----------------------------------------------------------------------------
// slm_dp
// Datapath of the level meter: magnitudes, squares, energy sum, counters,
// restoring divider, bitwise square root and the output register.
// ----------------------------------------------------------------------------
module slm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slm_pkg::in_req_t              in_req_i,
  input  logic [slm_pkg::THR_BITS-1:0]  clip_thr_i,
  input  slm_pkg::slm_cmd_t             cmd_i,
  output slm_pkg::slm_status_t          status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output slm_pkg::out_res_t             out_res_o
);
  import slm_pkg::*;

  // Request and frame registers
  in_req_t                req_q;
  logic [SAMPLE_BITS-1:0] mag_l_q, mag_r_q;
  logic [SQ_BITS-1:0]     sq_l_q, sq_r_q, half_e_q;

  // Measurement state
  logic [SAMPLE_BITS-1:0] peak_q;
  logic [ENERGY_BITS-1:0] energy_q;
  logic [COUNT_BITS-1:0]  frames_q, invalid_q, clip_q;

  // Divider and root
  logic [ITER_BITS-1:0]   iter_q;
  logic [COUNT_BITS-1:0]  rem_q;
  logic [ENERGY_BITS-1:0] quo_q;   // quotient, then the root's remainder
  logic [ENERGY_BITS-1:0] root_q, bit_q;

  // Output register
  logic     out_valid_q;
  out_res_t out_q;

  // Combinational helpers
  logic [SAMPLE_BITS-1:0]   mag_max;
  logic [SQ_BITS:0]         mix_sum;
  logic [ENERGY_BITS:0]     energy_sum;
  logic [COUNT_BITS:0]      rem_shift, rem_diff;
  logic [ENERGY_BITS-1:0]   root_trial;
  logic                     root_fits;
  logic                     out_free;
  logic                     is_read;
  out_res_t                 res_d;

  assign mag_max    = (mag_l_q > mag_r_q) ? mag_l_q : mag_r_q;
  assign mix_sum    = {1'b0, sq_l_q} + {1'b0, sq_r_q};
  assign energy_sum = {1'b0, energy_q} + {(ENERGY_BITS + 1 - SQ_BITS)'(0), half_e_q};
  assign rem_shift  = {rem_q, quo_q[ENERGY_BITS-1]};
  assign rem_diff   = rem_shift - {1'b0, frames_q};
  assign root_trial = root_q + bit_q;
  assign root_fits  = (quo_q >= root_trial);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_read    = (req_q.req_type == REQ_READ);

  // Status
  assign status_o.in_read      = (in_req_i.req_type == REQ_READ);
  assign status_o.in_nonfinite = in_req_i.nonfinite_in;
  assign status_o.frames_zero  = (frames_q == '0);
  assign status_o.div_last     = (iter_q == ITER_BITS'(DIV_STEPS - 1));
  assign status_o.root_last    = (iter_q == ITER_BITS'(ROOT_STEPS - 1));
  assign status_o.out_free     = out_free;

  // Request, squares and frame energy
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q   <= in_req_i;
      mag_l_q <= magnitude(in_req_i.left_in);
      mag_r_q <= magnitude(in_req_i.right_in);
    end
    if (cmd_i.square_l) begin
      sq_l_q <= SQ_BITS'(mag_l_q) * SQ_BITS'(mag_l_q);
    end
    if (cmd_i.square_r) begin
      sq_r_q <= SQ_BITS'(mag_r_q) * SQ_BITS'(mag_r_q);
    end
    if (cmd_i.mix) begin
      half_e_q <= mix_sum[SQ_BITS:1];
    end
  end

  // Divider and square root; the iteration counter wraps from the last
  // divide step straight to zero for the root
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      iter_q <= '0;
      rem_q  <= '0;
      quo_q  <= energy_q;
      root_q <= '0;
      bit_q  <= ENERGY_BITS'(1) << (ENERGY_BITS - 2);
    end else if (cmd_i.div_step) begin
      iter_q <= iter_q + ITER_BITS'(1);
      if (!rem_diff[COUNT_BITS]) begin
        rem_q <= rem_diff[COUNT_BITS-1:0];
      end else begin
        rem_q <= rem_shift[COUNT_BITS-1:0];
      end
      quo_q <= {quo_q[ENERGY_BITS-2:0], !rem_diff[COUNT_BITS]};
    end else if (cmd_i.root_step) begin
      iter_q <= iter_q + ITER_BITS'(1);
      if (root_fits) begin
        quo_q  <= quo_q - root_trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  // Measurement state: peak, clip and invalid totals, energy, frames
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q    <= '0;
      energy_q  <= '0;
      frames_q  <= '0;
      invalid_q <= '0;
      clip_q    <= '0;
    end else begin
      if (cmd_i.load && in_req_i.req_type == REQ_SAMPLE && in_req_i.nonfinite_in
          && invalid_q != '1) begin
        invalid_q <= invalid_q + COUNT_BITS'(1);
      end
      if (cmd_i.mix) begin
        if (mag_max > peak_q) begin
          peak_q <= mag_max;
        end
        if (mag_max > clip_thr_i && clip_q != '1) begin
          clip_q <= clip_q + COUNT_BITS'(1);
        end
      end
      if (cmd_i.accumulate) begin
        energy_q <= energy_sum[ENERGY_BITS] ? '1 : energy_sum[ENERGY_BITS-1:0];
        if (frames_q != '1) begin
          frames_q <= frames_q + COUNT_BITS'(1);
        end
      end
      // read clears the window after its result is captured
      if (cmd_i.emit && is_read) begin
        peak_q   <= '0;
        energy_q <= '0;
        frames_q <= '0;
      end
    end
  end

  // Result assembly
  always_comb begin
    res_d               = '0;
    res_d.invalid_count = invalid_q;
    res_d.clip_count    = clip_q;
    if (is_read) begin
      res_d.peak_level = peak_q;
      if (frames_q != '0) begin
        res_d.rms_level = root_q[SAMPLE_BITS-1:0];
      end
    end else if (!req_q.nonfinite_in) begin
      res_d.out_left  = req_q.left_in;
      res_d.out_right = req_q.right_in;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

### hw/rtl/stereo_level_meter_top.sv
// ----------------------------------------------------------------------------
// stereo_level_meter_top
// Stereo peak and RMS level meter with a clip threshold register.
// ----------------------------------------------------------------------------
// One request is processed at a time. A sample frame passes through the
// steps magnitudes, two squares through one multiply each, energy half-sum,
// saturating accumulate and result. A non-finite frame or a read with no
// frames counted goes from acceptance straight to the result step. A read
// with frames runs a one-bit-per-cycle restoring divider (energy sum over
// frame count) and then a one-bit-per-cycle square root before the result.
// A new request is taken while the previous result still waits in the
// output register; the block holds in its final step only if that register
// is still occupied.
// ----------------------------------------------------------------------------
module stereo_level_meter_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  slm_pkg::in_req_t                    in_req_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output slm_pkg::out_res_t                   out_res_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [slm_pkg::APB_ADDR_BITS-1:0]   paddr,
  input  logic [slm_pkg::APB_DATA_BITS-1:0]   pwdata,
  output logic [slm_pkg::APB_DATA_BITS-1:0]   prdata,
  output logic                                pready
);
  import slm_pkg::*;

  logic [THR_BITS-1:0]     clip_thr_q;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                    in_valid;
  slm_cmd_t                cmd;
  slm_status_t             status;

  assign reg_idx = paddr[APB_ADDR_BITS-1:2];
  assign pready  = 1'b1;

  // Clip threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_thr_q <= CLIP_THR_RESET;
    end else if (psel && penable && pwrite && pready && reg_idx == REG_CLIP_THRESHOLD) begin
      clip_thr_q <= pwdata[THR_BITS-1:0];
    end
  end

  // Register read
  always_comb begin
    prdata = '0;
    if (reg_idx == REG_CLIP_THRESHOLD) begin
      prdata = {(APB_DATA_BITS - THR_BITS)'(0), clip_thr_q};
    end
  end

  assign in_valid = in_valid_i;

  slm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slm_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .clip_thr_i  (clip_thr_q),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

endmodule

### test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo level meter. Requests go in over a
// valid/stall channel and every result is checked field by field against a
// cycle-free prediction of peak, RMS, clip and invalid tracking. The clip
// threshold is set over the APB port between phases and read back.
// ----------------------------------------------------------------------------
module tb_top;
  import slm_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 120;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned RAND_PHASES  = 4;
  localparam int unsigned RAND_ITEMS   = 245;
  // register index past the end of the map; writes to it must be dropped
  localparam int unsigned REG_UNMAPPED = 1;
  localparam logic [SAMPLE_BITS-1:0] MOST_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] MOST_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  in_req_t                  in_req_i    = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  out_res_t                 out_res_o;
  logic                     psel        = 1'b0;
  logic                     penable     = 1'b0;
  logic                     pwrite      = 1'b0;
  logic [APB_ADDR_BITS-1:0] paddr       = '0;
  logic [APB_DATA_BITS-1:0] pwdata      = '0;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;

  stereo_level_meter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // Meter state as the bench expects it
  logic [THR_BITS-1:0]    thr_level   = CLIP_THR_RESET;
  logic [SAMPLE_BITS-1:0] peak_mag    = '0;
  logic [63:0]            energy_acc  = '0;
  logic [COUNT_BITS-1:0]  frame_cnt   = '0;
  logic [COUNT_BITS-1:0]  invalid_cnt = '0;
  logic [COUNT_BITS-1:0]  clip_cnt    = '0;

  out_res_t    meter_results_q[$];
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_cycles = 0;
  bit          quiet_link  = 1'b0;

  // Magnitude of a Q2.22 sample, computed in one extra bit
  function automatic logic [SAMPLE_BITS-1:0] sample_mag(logic [SAMPLE_BITS-1:0] s);
    logic [SAMPLE_BITS:0] wide;
    wide = s[SAMPLE_BITS-1] ? ({1'b1, {SAMPLE_BITS{1'b0}}} - {1'b0, s}) : {1'b0, s};
    return wide[SAMPLE_BITS-1:0];
  endfunction

  // Integer square root, one result bit at a time from the top
  function automatic logic [63:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // Expected result of one request; advances the meter state
  function automatic out_res_t meter_response(in_req_t req);
    out_res_t               res;
    logic [SAMPLE_BITS-1:0] mag_l;
    logic [SAMPLE_BITS-1:0] mag_r;
    logic [SAMPLE_BITS-1:0] mag_max;
    logic [63:0]            half_energy;
    res = '0;
    if (req.req_type == REQ_READ) begin
      if (frame_cnt != '0)
        res.rms_level = SAMPLE_BITS'(floor_sqrt(energy_acc / 64'(frame_cnt)));
      res.peak_level = peak_mag;
      energy_acc = '0;
      frame_cnt  = '0;
      peak_mag   = '0;
    end else if (req.nonfinite_in) begin
      if (invalid_cnt != '1) invalid_cnt++;
    end else begin
      mag_l   = sample_mag(req.left_in);
      mag_r   = sample_mag(req.right_in);
      mag_max = (mag_l > mag_r) ? mag_l : mag_r;
      half_energy = (64'(mag_l) * 64'(mag_l) + 64'(mag_r) * 64'(mag_r)) >> 1;
      if (mag_max > thr_level && clip_cnt != '1) clip_cnt++;
      if (mag_max > peak_mag) peak_mag = mag_max;
      // ~half_energy is the headroom left below all ones
      energy_acc = (energy_acc > ~half_energy) ? '1 : energy_acc + half_energy;
      if (frame_cnt != '1) frame_cnt++;
      res.out_left  = req.left_in;
      res.out_right = req.right_in;
    end
    res.invalid_count = invalid_cnt;
    res.clip_count    = clip_cnt;
    return res;
  endfunction

  function automatic void note_error(string what, logic [63:0] want, logic [63:0] got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch on %s: expected %h, got %h", what, want, got);
  endfunction

  function automatic in_req_t make_req(req_type_e kind, logic [SAMPLE_BITS-1:0] l,
                                       logic [SAMPLE_BITS-1:0] r, logic nonfinite);
    in_req_t req;
    req.req_type     = kind;
    req.left_in      = l;
    req.right_in     = r;
    req.nonfinite_in = nonfinite;
    return req;
  endfunction

  // Random sample weighted toward extremes and the clip boundary
  function automatic logic [SAMPLE_BITS-1:0] random_sample();
    int mag;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return MOST_NEG;
          1:       return MOST_POS;
          2:       return '0;
          3:       return SAMPLE_BITS'(1);
          default: return '1;
        endcase
      end
      1, 2: begin
        mag = int'(thr_level) + int'($urandom_range(0, 2)) - 1;
        if (mag < 0) mag = 0;
        if (mag >= (1 << (SAMPLE_BITS - 1))) return MOST_NEG;
        return $urandom_range(0, 1) ? SAMPLE_BITS'(-mag) : SAMPLE_BITS'(mag);
      end
      3:       return SAMPLE_BITS'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic in_req_t random_request();
    in_req_t     req;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    req  = make_req(REQ_SAMPLE, random_sample(), random_sample(), 1'b0);
    if (pick < 5) begin
      req.req_type     = REQ_READ;
      req.nonfinite_in = 1'($urandom_range(0, 1));
    end else if (pick < 9) begin
      req.nonfinite_in = 1'b1;
    end
    return req;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned pick;
    if (quiet_link) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Send one request; entered and left at a rising edge, valid left high
  task automatic send_request(input in_req_t req);
    int unsigned gap;
    bit          taken;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    meter_results_q.push_back(meter_response(req));
  endtask

  // Drop valid and let every outstanding result drain
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (meter_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input int unsigned idx, input logic [APB_DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_BITS'(idx * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == 32'(REG_CLIP_THRESHOLD)) thr_level = value[THR_BITS-1:0];
    @(posedge clk_i);
  endtask

  // Read the threshold back and compare with the bench copy
  task automatic check_threshold();
    logic [APB_DATA_BITS-1:0] value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= APB_ADDR_BITS'(32'(REG_CLIP_THRESHOLD) * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    value = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (value !== APB_DATA_BITS'(thr_level)) note_error("clip_threshold readback",
                                                        64'(thr_level), 64'(value));
    @(posedge clk_i);
  endtask

  task automatic set_threshold(input logic [APB_DATA_BITS-1:0] value);
    wait_idle();
    cfg_write(32'(REG_CLIP_THRESHOLD), value);
    check_threshold();
  endtask

  // Reset value of the register, and a read before any frame
  task automatic test_reset_state();
    check_threshold();
    send_request(make_req(REQ_READ, '0, '0, 1'b0));
  endtask

  // Field extremes, clip boundary, non-finite frames and reads
  task automatic test_directed_cases();
    send_request(make_req(REQ_SAMPLE, '0, '0, 1'b0));
    send_request(make_req(REQ_SAMPLE, MOST_POS, MOST_POS, 1'b0));
    send_request(make_req(REQ_SAMPLE, MOST_NEG, MOST_NEG, 1'b0));
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(4194304), SAMPLE_BITS'(-4194304), 1'b0));
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(4194305), '0, 1'b0));
    send_request(make_req(REQ_SAMPLE, '0, SAMPLE_BITS'(-4194305), 1'b0));
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(1), SAMPLE_BITS'(-1), 1'b0));
    // non-finite frame carries a payload that must not reach any state
    send_request(make_req(REQ_SAMPLE, MOST_NEG, MOST_POS, 1'b1));
    // read ignores payload and the non-finite flag
    send_request(make_req(REQ_READ, MOST_NEG, MOST_POS, 1'b1));
    send_request(make_req(REQ_READ, '0, '0, 1'b0));
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(7), SAMPLE_BITS'(7), 1'b1));
    send_request(make_req(REQ_SAMPLE, '1, '1, 1'b1));
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(3), SAMPLE_BITS'(5), 1'b0));
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(-7), SAMPLE_BITS'(2), 1'b0));
    send_request(make_req(REQ_READ, '0, '0, 1'b0));
    // most negative sample alone: peak must be exactly 2^23
    send_request(make_req(REQ_SAMPLE, MOST_NEG, '0, 1'b0));
    send_request(make_req(REQ_READ, '0, '0, 1'b0));
  endtask

  // Threshold at zero and at the largest sample magnitude, and a write to an unmapped index
  task automatic test_threshold_extremes();
    set_threshold('0);
    send_request(make_req(REQ_SAMPLE, '0, '0, 1'b0));
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(1), '0, 1'b0));
    send_request(make_req(REQ_SAMPLE, '0, '1, 1'b0));
    send_request(make_req(REQ_READ, '0, '0, 1'b0));
    set_threshold(32'd8388608);
    send_request(make_req(REQ_SAMPLE, MOST_POS, SAMPLE_BITS'(-8388607), 1'b0));
    send_request(make_req(REQ_SAMPLE, MOST_NEG, '0, 1'b0));
    send_request(make_req(REQ_READ, '0, '0, 1'b0));
    wait_idle();
    cfg_write(REG_UNMAPPED, 32'd5);
    check_threshold();
    send_request(make_req(REQ_SAMPLE, SAMPLE_BITS'(6), '0, 1'b0));
  endtask

  // Long receiver hold while requests keep coming back to back
  task automatic test_output_backpressure();
    set_threshold(APB_DATA_BITS'(CLIP_THR_RESET));
    quiet_link  = 1'b1;
    hold_cycles = HOLD_CYCLES;
    for (int i = 0; i < 24; i++) begin
      send_request(make_req(REQ_SAMPLE, random_sample(), random_sample(), 1'b0));
      if (i % 12 == 11) send_request(make_req(REQ_READ, '0, '0, 1'b0));
    end
    quiet_link = 1'b0;
  endtask

  // Random traffic over several threshold settings
  task automatic test_random_traffic();
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      case (phase)
        0:       set_threshold($urandom_range(0, 8388608));
        1:       set_threshold($urandom_range(0, 255));
        2:       set_threshold(32'd8388607);
        default: set_threshold(APB_DATA_BITS'(CLIP_THR_RESET));
      endcase
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if (i % 50 == 0) quiet_link = ($urandom_range(0, 3) == 0);
        send_request(random_request());
      end
      quiet_link = 1'b0;
    end
  endtask

  // Result side stall: short bursts, rare long ones, and the forced hold
  initial begin : result_stall
    int unsigned stall_left;
    int unsigned pick;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles != 0) begin
        stall_left  = hold_cycles;
        hold_cycles = 0;
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left--;
      end else begin
        out_stall_i <= 1'b0;
        pick = $urandom_range(0, 99);
        if (!quiet_link && rst_ni) begin
          if (pick < 15) stall_left = $urandom_range(1, 3);
          else if (pick < 17) stall_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  initial begin : result_check
    out_res_t got;
    out_res_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = out_res_o;
        if (meter_results_q.size() == 0) begin
          note_error("result with nothing pending", '0, 64'(got.clip_count));
        end else begin
          want = meter_results_q.pop_front();
          if (got.out_left !== want.out_left)
            note_error("out_left", 64'(want.out_left), 64'(got.out_left));
          if (got.out_right !== want.out_right)
            note_error("out_right", 64'(want.out_right), 64'(got.out_right));
          if (got.rms_level !== want.rms_level)
            note_error("rms_level", 64'(want.rms_level), 64'(got.rms_level));
          if (got.peak_level !== want.peak_level)
            note_error("peak_level", 64'(want.peak_level), 64'(got.peak_level));
          if (got.invalid_count !== want.invalid_count)
            note_error("invalid_count", 64'(want.invalid_count), 64'(got.invalid_count));
          if (got.clip_count !== want.clip_count)
            note_error("clip_count", 64'(want.clip_count), 64'(got.clip_count));
        end
      end
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed_cases();
    test_threshold_extremes();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && meter_results_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
